FILE: hdl/eehe_pkg.sv
// shared types and constants for the ebml element header encoder
// no dependencies; imported by every module of the block
`default_nettype none

package eehe_pkg;

    // operation codes
    localparam logic [2:0] OP_UINT   = 3'd0;
    localparam logic [2:0] OP_SINT   = 3'd1;
    localparam logic [2:0] OP_FLOAT  = 3'd2;
    localparam logic [2:0] OP_HEADER = 3'd3;
    localparam logic [2:0] OP_MASTER = 3'd4;
    localparam logic [2:0] OP_SIZE   = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_ID   = 2'd1;
    localparam logic [1:0] ERR_SIZE = 2'd2;

    // default depth of the queue between classifier and serialiser
    localparam int QUEUE_DEPTH_DEF = 2;

    // one classified element, the byte fields left aligned (first byte on top)
    typedef struct packed {
        logic [1:0]  err;
        logic [31:0] id_al;
        logic [2:0]  idn;
        logic [63:0] sz_al;
        logic [3:0]  szn;
        logic [63:0] bd_al;
        logic [3:0]  total;
    } t_desc;

    // push side of the queue
    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_push;

    // pop side of the queue
    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_head;

endpackage

`default_nettype wire

FILE: hdl/eehe_front.sv
// classifier: decodes one element request into a byte-plan descriptor
// depends on eehe_pkg
`default_nettype none

module eehe_front import eehe_pkg::*; (
    input  wire logic        i_valid,
    input  wire logic [2:0]  i_operation,
    input  wire logic [31:0] i_element_id,
    input  wire logic [63:0] i_value,
    input  wire logic [3:0]  i_size_width,
    input  wire logic        i_full,
    output logic             o_stall,
    output t_push            o_push
);

    function automatic logic [3:0] byte_count(input logic [63:0] t);
        logic [3:0] n;
        n = 4'd1;
        for (int k = 1; k < 8; k++) begin
            if ((t >> (8 * k)) != 64'd0) begin
                n = 4'(k + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] size_marker(input logic [3:0] w);
        logic [63:0] m;
        m = '0;
        for (int k = 1; k <= 8; k++) begin
            if (w == 4'(k)) begin
                m = 64'd1 << (7 * k);
            end
        end
        return m;
    endfunction

    function automatic logic [63:0] left_align(input logic [63:0] x, input logic [3:0] n);
        logic [63:0] r;
        r = x;
        for (int k = 1; k <= 8; k++) begin
            if (n == 4'(k)) begin
                r = x << (8 * (8 - k));
            end
        end
        return r;
    endfunction

    logic [64:0] v1;
    logic [7:0]  fits;
    logic [3:0]  min_w;
    logic [3:0]  swm1;
    logic [7:0]  top_b;
    logic [2:0]  idl;
    logic [31:0] id_al;
    logic [3:0]  w;
    logic [63:0] szval;
    logic [63:0] mag;
    logic [3:0]  bdn;
    logic [2:0]  idn;
    logic [1:0]  err;
    logic        keep;

    assign o_stall = i_full;

    // size width tests: value fits in w bytes when value + 1 < 2^(7w)
    always_comb begin
        v1 = {1'b0, i_value} + 65'd1;
        for (int k = 1; k <= 8; k++) begin
            fits[k - 1] = (v1 >> (7 * k)) == 65'd0;
        end
        min_w = 4'd9;
        for (int k = 8; k >= 1; k--) begin
            if (fits[k - 1]) begin
                min_w = 4'(k);
            end
        end
        swm1 = i_size_width - 4'd1;
    end

    // id length from the marker bit of the first nonzero byte
    always_comb begin
        if (i_element_id[31:24] != 8'd0) begin
            top_b = i_element_id[31:24];
        end else if (i_element_id[23:16] != 8'd0) begin
            top_b = i_element_id[23:16];
        end else if (i_element_id[15:8] != 8'd0) begin
            top_b = i_element_id[15:8];
        end else begin
            top_b = i_element_id[7:0];
        end
        if (top_b[7]) begin
            idl = 3'd1;
        end else if (top_b[6]) begin
            idl = 3'd2;
        end else if (top_b[5]) begin
            idl = 3'd3;
        end else if (top_b[4]) begin
            idl = 3'd4;
        end else begin
            idl = 3'd0;
        end
        id_al = i_element_id;
        for (int k = 1; k <= 4; k++) begin
            if (idl == 3'(k)) begin
                id_al = i_element_id << (8 * (4 - k));
            end
        end
    end

    always_comb begin
        err   = ERR_NONE;
        keep  = 1'b1;
        w     = 4'd1;
        szval = '0;
        bdn   = 4'd0;
        idn   = idl;
        mag   = i_value[63] ? ~i_value : i_value;
        case (i_operation)
            OP_SIZE: begin
                idn = 3'd0;
                if (i_size_width == 4'd0) begin
                    w = min_w;
                    if (min_w == 4'd9) begin
                        err = ERR_SIZE;
                    end
                end else if (i_size_width > 4'd8) begin
                    err = ERR_SIZE;
                end else begin
                    w = i_size_width;
                    if (!fits[swm1[2:0]]) begin
                        err = ERR_SIZE;
                    end
                end
                szval = i_value | size_marker(w);
            end
            OP_UINT: begin
                bdn   = byte_count(i_value);
                szval = {56'd0, 4'h8, bdn};
            end
            OP_SINT: begin
                bdn   = byte_count(mag << 1);
                szval = {56'd0, 4'h8, bdn};
            end
            OP_FLOAT: begin
                bdn   = 4'd8;
                szval = 64'h88;
            end
            OP_HEADER: begin
                w = min_w;
                if (min_w == 4'd9) begin
                    err = ERR_SIZE;
                end
                szval = i_value | size_marker(w);
            end
            OP_MASTER: begin
                // unknown size: marker and all bits below it set
                w = (i_value == 64'd0) ? 4'd8 : min_w;
                if (w == 4'd9) begin
                    err = ERR_SIZE;
                end
                szval = (size_marker(w) << 1) - 64'd1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
        // id errors take precedence over size errors
        if (i_operation != OP_SIZE && idl == 3'd0) begin
            err = ERR_ID;
        end

        o_push.valid      = i_valid && !i_full && keep;
        o_push.desc.err   = err;
        o_push.desc.id_al = id_al;
        o_push.desc.idn   = idn;
        o_push.desc.sz_al = left_align(szval, w);
        o_push.desc.szn   = w;
        o_push.desc.bd_al = left_align(i_value, bdn);
        o_push.desc.total = (err != ERR_NONE) ? 4'd1 : (4'(idn) + w + bdn);
    end

endmodule

`default_nettype wire

FILE: hdl/eehe_queue.sv
// small descriptor queue between classifier and serialiser
// depends on eehe_pkg
`default_nettype none

module eehe_queue import eehe_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output logic       o_full,
    output t_head      o_head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_desc            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_pop;

    assign o_full      = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_head.valid = r_count != '0;
    assign o_head.desc  = r_mem[r_rd_ptr];
    assign do_pop      = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push.valid && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !i_push.valid) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/eehe_back.sv
// serialiser: walks one descriptor out as bytes into an output register
// depends on eehe_pkg
`default_nettype none

module eehe_back import eehe_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_head      i_head,
    output logic            o_pop,
    input  wire logic       i_stall,
    output logic            o_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic [1:0]      o_error_code
);

    logic        r_busy, n_busy;
    logic [1:0]  r_err, n_err;
    logic [31:0] r_id_sh, n_id_sh;
    logic [2:0]  r_idn, n_idn;
    logic [63:0] r_sz_sh, n_sz_sh;
    logic [3:0]  r_szn, n_szn;
    logic [63:0] r_bd_sh, n_bd_sh;
    logic [3:0]  r_rem, n_rem;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_obyte, n_obyte;
    logic        r_olast, n_olast;
    logic [1:0]  r_oerr, n_oerr;

    logic        emit;
    logic        cur_last;
    logic [7:0]  cur_byte;

    assign o_valid      = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_last       = r_olast;
    assign o_error_code = r_oerr;

    always_comb begin
        emit     = r_busy && (!r_ovalid || !i_stall);
        cur_last = (r_err != ERR_NONE) || (r_rem == 4'd1);
        if (r_err != ERR_NONE) begin
            cur_byte = 8'd0;
        end else if (r_idn != 3'd0) begin
            cur_byte = r_id_sh[31:24];
        end else if (r_szn != 4'd0) begin
            cur_byte = r_sz_sh[63:56];
        end else begin
            cur_byte = r_bd_sh[63:56];
        end
        // next descriptor loads in the cycle the last byte leaves
        o_pop = i_head.valid && (!r_busy || (emit && cur_last));

        n_busy  = r_busy;
        n_err   = r_err;
        n_id_sh = r_id_sh;
        n_idn   = r_idn;
        n_sz_sh = r_sz_sh;
        n_szn   = r_szn;
        n_bd_sh = r_bd_sh;
        n_rem   = r_rem;
        if (o_pop) begin
            n_busy  = 1'b1;
            n_err   = i_head.desc.err;
            n_id_sh = i_head.desc.id_al;
            n_idn   = i_head.desc.idn;
            n_sz_sh = i_head.desc.sz_al;
            n_szn   = i_head.desc.szn;
            n_bd_sh = i_head.desc.bd_al;
            n_rem   = i_head.desc.total;
        end else if (emit && cur_last) begin
            n_busy = 1'b0;
        end else if (emit) begin
            n_rem = r_rem - 4'd1;
            if (r_idn != 3'd0) begin
                n_idn   = r_idn - 3'd1;
                n_id_sh = r_id_sh << 8;
            end else if (r_szn != 4'd0) begin
                n_szn   = r_szn - 4'd1;
                n_sz_sh = r_sz_sh << 8;
            end else begin
                n_bd_sh = r_bd_sh << 8;
            end
        end

        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        n_oerr   = r_oerr;
        if (emit) begin
            n_ovalid = 1'b1;
            n_obyte  = cur_byte;
            n_olast  = cur_last;
            n_oerr   = r_err;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ovalid <= n_ovalid;
        end
        r_err   <= n_err;
        r_id_sh <= n_id_sh;
        r_idn   <= n_idn;
        r_sz_sh <= n_sz_sh;
        r_szn   <= n_szn;
        r_bd_sh <= n_bd_sh;
        r_rem   <= n_rem;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_oerr  <= n_oerr;
    end

endmodule

`default_nettype wire

FILE: hdl/ebml_element_header_encoder.sv
// top level of the ebml element header encoder
// depends on eehe_pkg, eehe_front, eehe_queue and eehe_back
`default_nettype none

// Turns one element request per input transfer into the EBML bytes of that
// element, one byte per output transfer, most significant byte first, with
// o_last on the final byte. Except for the size operation, the element id
// goes out first in the length given by its marker bit (1 to 4 bytes); then
// the size as a variable-length integer (minimal or forced width, or all
// ones for an open master), then for the integer and float operations the
// value itself. A bad id, or a size that needs more than 8 bytes or more
// than its forced width, or a forced width above 8, gives a single transfer
// with byte 0, o_last high and the error code. Operation codes 6 and 7 are
// taken and give nothing.
// Rate: an item has 1 to 13 output bytes; the serialiser moves one byte per
// cycle while the output is not stalled and loads the next item in the same
// cycle as the last byte. The classifier answers in the accepting cycle and
// a QUEUE_DEPTH-entry queue lets input transfers run ahead of the byte stream.
module ebml_element_header_encoder import eehe_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic [31:0] i_element_id,
    input  wire logic [63:0] i_value,
    input  wire logic [3:0]  i_size_width,
    // byte channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last,
    output logic [1:0]       o_error_code
);

    t_push push;
    t_head head;
    logic  q_full;
    logic  pop;

    // front: classify the request and work out the byte plan
    eehe_front u_front (
        .i_valid      (i_valid),
        .i_operation  (i_operation),
        .i_element_id (i_element_id),
        .i_value      (i_value),
        .i_size_width (i_size_width),
        .i_full       (q_full),
        .o_stall      (o_stall),
        .o_push       (push)
    );

    // queue: decouples request acceptance from the byte stream
    eehe_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    // back: shift the plan out one byte per transfer
    eehe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last),
        .o_error_code (o_error_code)
    );

endmodule

`default_nettype wire
